// ----- sv/wpd_pkg.sv -----
// Shared types and constants for the word packet deframer.
package wpd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 5;   // word_count field
    localparam int OUT_IDX_W  = 5;   // word_index field
    localparam int DATA_W     = 32;  // data_word field
    localparam int M_TDATA_W  = 56;  // 51 payload bits, padded to whole bytes
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic take_id;
        logic take_count;
        logic store_byte;
        logic tail_ok;
        logic rd_issue;
        logic load_word;
        logic load_empty;
    } wpd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hdr_match;
        logic tail_match;
        logic cnt_zero;
        logic cnt_big;
        logic data_done;
        logic words_zero;
        logic emit_last;
        logic out_free;
    } wpd_sts_t;

endpackage

// ----- sv/word_packet_deframer.sv -----
// Top level of the length-prefixed word packet deframer.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tdata: rx_byte
//  m_      | out | m_tvalid / m_tready  | m_tdata, m_tuser (has_word), m_tlast (last)
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (0 header, 1 tail)
//
// Frame: header, device id, word count, count * WORD_BYTES data bytes, tail.
// Header, id, count and data bytes go in at one beat per cycle; the tail beat
// waits until the output register is free.
// After a good tail the input side is held off while the words are read back
// from the word store, each through the read port and then the output
// register; the read-back waits whenever the result side stalls.
// The last result of a frame sits in the output register while the next frame
// is already being taken. Reset is synchronous, active low; the store needs no
// clearing, every word read was written earlier in the same frame.
module word_packet_deframer #(
    parameter int MAX_WORDS  = 30,
    parameter int WORD_BYTES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // byte in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wpd_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] rx_byte
    // results out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] source_id, [12:8] word_count, [17:13] word_index,
    // [49:18] data_word, [50] return_enable, [55:51] zero
    output logic [wpd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser,   // [0] has_word
    output logic                                m_tlast,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wpd_pkg::BYTE_W-1:0]          cfg_data
);

    wpd_pkg::wpd_cmd_t cmd;
    wpd_pkg::wpd_sts_t sts;

    // writes are to arrive only while idle; the block does not enforce it and always takes them
    assign cfg_ready = 1'b1;

    wpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpd_datapath #(
        .MAX_WORDS  (MAX_WORDS),
        .WORD_BYTES (WORD_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // no input beat is taken while the store is being read back
    a_no_input_in_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> !s_tready)
        else $error("input accepted during read-back");

    // an empty frame result is a single, last beat carrying a zero word
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[49:18] == 32'd0))
        else $error("empty result malformed");

    // the last word of a run sits at index count - 1
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && m_tlast) |->
            (m_tdata[17:13] + 5'd1 == m_tdata[12:8]))
        else $error("last word index does not match word count");

    // a result is only loaded when the output register can take it
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_word || cmd.load_empty) |-> sts.out_free)
        else $error("result loaded over a pending beat");
`endif

endmodule

// ----- sv/wpd_ctrl.sv -----
// Frame parsing and result sequencing state machine.
module wpd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wpd_pkg::wpd_sts_t sts,
    output wpd_pkg::wpd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ID,
        ST_COUNT,
        ST_DATA,
        ST_TAIL,
        ST_RD,
        ST_LD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_HUNT: begin
                s_tready = 1'b1;
                if (s_tvalid && sts.hdr_match) begin
                    state_next = ST_ID;
                end
            end
            ST_ID: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_id = 1'b1;
                    state_next  = ST_COUNT;
                end
            end
            ST_COUNT: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_count = 1'b1;
                    if (sts.cnt_zero) begin
                        state_next = ST_TAIL;
                    end else if (sts.cnt_big) begin
                        state_next = ST_HUNT;
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.store_byte = 1'b1;
                    if (sts.data_done) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                // an empty frame's result goes straight to the output register
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    if (sts.tail_match) begin
                        cmd.tail_ok = 1'b1;
                        if (sts.words_zero) begin
                            cmd.load_empty = 1'b1;
                            state_next     = ST_HUNT;
                        end else begin
                            state_next = ST_RD;
                        end
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LD;
            end
            ST_LD: begin
                if (sts.out_free) begin
                    cmd.load_word = 1'b1;
                    state_next    = sts.emit_last ? ST_HUNT : ST_RD;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/wpd_datapath.sv -----
// Config registers, frame counters, word store and output register.
module wpd_datapath #(
    parameter int MAX_WORDS  = 30,
    parameter int WORD_BYTES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wpd_pkg::wpd_cmd_t                   cmd,
    output wpd_pkg::wpd_sts_t                   sts,
    input  logic [wpd_pkg::BYTE_W-1:0]          rx_byte,
    input  logic                                cfg_we,
    input  logic [wpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wpd_pkg::BYTE_W-1:0]          cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wpd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int WCNT_W = $clog2(MAX_WORDS + 1);
    localparam int IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LANE_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam int NLANES = (WORD_BYTES < 4) ? WORD_BYTES : 4;
    localparam int DW     = wpd_pkg::DATA_W;
    localparam int BW     = wpd_pkg::BYTE_W;

    logic [BW-1:0]     hdr_reg, hdr_next;
    logic [BW-1:0]     tail_reg, tail_next;
    logic [BW-1:0]     dev_reg, dev_next;
    logic [WCNT_W-1:0] words_reg, words_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [IDX_W-1:0]  eidx_reg, eidx_next;
    logic [DW-1:0]     asm_reg, asm_next;
    logic              w0nz_reg, w0nz_next;
    logic              flag_reg, flag_next;
    logic [DW-1:0]     rd_data_reg;

    logic [DW-1:0]     mem [MAX_WORDS];

    logic              mvalid_reg, mvalid_next;
    logic [BW-1:0]     odev_reg, odev_next;
    logic [wpd_pkg::CNT_W-1:0]     ocnt_reg, ocnt_next;
    logic [wpd_pkg::OUT_IDX_W-1:0] oidx_reg, oidx_next;
    logic [DW-1:0]     oword_reg, oword_next;
    logic              oflag_reg, oflag_next;
    logic              ohas_reg, ohas_next;
    logic              olast_reg, olast_next;

    logic              lane_last;
    logic [DW-1:0]     word_full;
    logic [BW-1:0]     words8;
    logic [BW-1:0]     eidx8;
    logic              out_free;

    assign lane_last = (lane_reg == LANE_W'(WORD_BYTES - 1));
    assign words8    = BW'(words_reg);
    assign eidx8     = BW'(eidx_reg);
    assign out_free  = !mvalid_reg || m_tready;

    // byte lanes beyond the fourth do not reach the 32-bit word
    always_comb begin
        word_full = (lane_reg == '0) ? '0 : asm_reg;
        for (int k = 0; k < NLANES; k++) begin
            if (lane_reg == LANE_W'(k)) begin
                word_full[8*k +: 8] = rx_byte;
            end
        end
    end

    always_comb begin
        sts            = '0;
        sts.hdr_match  = (rx_byte == hdr_reg);
        sts.tail_match = (rx_byte == tail_reg);
        sts.cnt_zero   = (rx_byte == '0);
        sts.cnt_big    = (rx_byte > BW'(MAX_WORDS));
        sts.data_done  = lane_last && (WCNT_W'(widx_reg) == words_reg - WCNT_W'(1));
        sts.words_zero = (words_reg == '0);
        sts.emit_last  = (WCNT_W'(eidx_reg) == words_reg - WCNT_W'(1));
        sts.out_free   = out_free;
    end

    always_comb begin
        hdr_next   = hdr_reg;
        tail_next  = tail_reg;
        dev_next   = dev_reg;
        words_next = words_reg;
        lane_next  = lane_reg;
        widx_next  = widx_reg;
        eidx_next  = eidx_reg;
        asm_next   = asm_reg;
        w0nz_next  = w0nz_reg;
        flag_next  = flag_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                wpd_pkg::REG_HEADER: hdr_next  = cfg_data;
                wpd_pkg::REG_TAIL:   tail_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.take_id) begin
            dev_next = rx_byte;
        end
        if (cmd.take_count) begin
            if (!sts.cnt_big) begin
                words_next = WCNT_W'(rx_byte);
            end
            lane_next = '0;
            widx_next = '0;
        end
        if (cmd.store_byte) begin
            asm_next  = word_full;
            lane_next = lane_last ? '0 : lane_reg + LANE_W'(1);
            if (lane_last) begin
                widx_next = widx_reg + IDX_W'(1);
                if (widx_reg == '0) begin
                    w0nz_next = |word_full;
                end
            end
        end
        if (cmd.tail_ok) begin
            eidx_next = '0;
            if (words_reg == WCNT_W'(1)) begin
                flag_next = w0nz_reg;
            end
        end
        if (cmd.load_word) begin
            eidx_next = eidx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        odev_next   = odev_reg;
        ocnt_next   = ocnt_reg;
        oidx_next   = oidx_reg;
        oword_next  = oword_reg;
        oflag_next  = oflag_reg;
        ohas_next   = ohas_reg;
        olast_next  = olast_reg;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        if (cmd.load_word || cmd.load_empty) begin
            mvalid_next = 1'b1;
            odev_next   = dev_reg;
            ocnt_next   = words8[wpd_pkg::CNT_W-1:0];
            oflag_next  = flag_next;
            ohas_next   = cmd.load_word;
            if (cmd.load_word) begin
                oidx_next  = eidx8[wpd_pkg::OUT_IDX_W-1:0];
                oword_next = rd_data_reg;
                olast_next = sts.emit_last;
            end else begin
                oidx_next  = '0;
                oword_next = '0;
                olast_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg    <= '0;
            tail_reg   <= '0;
            dev_reg    <= '0;
            words_reg  <= '0;
            lane_reg   <= '0;
            widx_reg   <= '0;
            eidx_reg   <= '0;
            w0nz_reg   <= 1'b0;
            flag_reg   <= 1'b1;
            mvalid_reg <= 1'b0;
        end else begin
            hdr_reg    <= hdr_next;
            tail_reg   <= tail_next;
            dev_reg    <= dev_next;
            words_reg  <= words_next;
            lane_reg   <= lane_next;
            widx_reg   <= widx_next;
            eidx_reg   <= eidx_next;
            w0nz_reg   <= w0nz_next;
            flag_reg   <= flag_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        asm_reg   <= asm_next;
        odev_reg  <= odev_next;
        ocnt_reg  <= ocnt_next;
        oidx_reg  <= oidx_next;
        oword_reg <= oword_next;
        oflag_reg <= oflag_next;
        ohas_reg  <= ohas_next;
        olast_reg <= olast_next;
    end

    // word store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.store_byte && lane_last) begin
            mem[widx_reg] <= word_full;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[eidx_reg];
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = ohas_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'b0, oflag_reg, oword_reg, oidx_reg, ocnt_reg, odev_reg};

endmodule

// ----- verif/word_packet_deframer_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for word_packet_deframer: frame parsing, word assembly, return flag.
module word_packet_deframer_test;

    localparam int MAX_WORDS      = 30;
    localparam int WORD_BYTES     = 4;
    localparam int STORE_BYTES    = MAX_WORDS * WORD_BYTES;
    localparam int SETTLE_CYCLES  = 16;    // word store read-back has drained well within this
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat on any channel
    localparam int REPORT_LIMIT   = 10;

    // register indexes with no register behind them; writes must be ignored
    localparam logic [wpd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [wpd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [2:0] {
        HUNT,
        GET_ID,
        GET_COUNT,
        GET_DATA,
        GET_TAIL
    } parse_phase_t;

    // one expected result beat
    typedef struct packed {
        logic [7:0]  device;
        logic [4:0]  n_words;
        logic        has_word;
        logic [4:0]  index;
        logic [31:0] word;
        logic        ret_en;
        logic        last;
    } frame_word_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [wpd_pkg::BYTE_W-1:0]       s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [wpd_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [wpd_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [wpd_pkg::BYTE_W-1:0]       cfg_data;

    word_packet_deframer #(
        .MAX_WORDS  (MAX_WORDS),
        .WORD_BYTES (WORD_BYTES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Parser mirror: registers, parse state and the word store
    // ------------------------------------------------------------------
    logic [7:0]    hdr_value;
    logic [7:0]    tail_value;
    parse_phase_t  phase;
    int unsigned   data_seen;
    int unsigned   data_due;
    logic [7:0]    dev_id;
    logic [4:0]    n_words;
    logic [7:0]    payload [STORE_BYTES];
    logic          ret_flag;

    frame_word_t   pending_words [$];   // results owed by the block, oldest first

    bit            gaps_on;             // random idling on both sides
    int unsigned   beats_sent;          // beats that do more than get skipped while hunting
    int            mismatch_count;
    int unsigned   idle_cycles;
    int unsigned   stall_left;

    // little-endian: first byte of the word lands in bits [7:0]
    function automatic logic [31:0] payload_word(input int unsigned w);
        logic [31:0] v;
        v = '0;
        for (int b = 0; b < WORD_BYTES; b++)
            v[8*b +: 8] = payload[w*WORD_BYTES + b];
        return v;
    endfunction

    // advance the mirror by one accepted byte, queueing any results it completes
    function automatic void parse_byte(input logic [7:0] b);
        frame_word_t r;
        case (phase)
            HUNT: begin
                if (b == hdr_value) begin
                    data_seen = 0;
                    phase     = GET_ID;
                end
            end
            GET_ID: begin
                dev_id = b;
                phase  = GET_COUNT;
            end
            GET_COUNT: begin
                if (b == 8'd0) begin
                    n_words  = '0;
                    data_due = 0;
                    phase    = GET_TAIL;
                end else if (b > MAX_WORDS) begin
                    phase = HUNT;      // oversize count: drop, count byte is not a header
                end else begin
                    n_words   = b[4:0];
                    data_due  = b * WORD_BYTES;
                    data_seen = 0;
                    phase     = GET_DATA;
                end
            end
            GET_DATA: begin
                if (data_seen < STORE_BYTES)
                    payload[data_seen] = b;
                data_seen++;
                if (data_seen >= data_due)
                    phase = GET_TAIL;
            end
            GET_TAIL: begin
                if (b == tail_value) begin
                    // single-word frames steer the return flag; it is reported already updated
                    if (n_words == 5'd1)
                        ret_flag = (payload_word(0) != 32'd0);
                    if (n_words == 5'd0) begin
                        r = '{device: dev_id, n_words: 5'd0, has_word: 1'b0, index: 5'd0,
                              word: 32'd0, ret_en: ret_flag, last: 1'b1};
                        pending_words.push_back(r);
                    end else begin
                        for (int w = 0; w < n_words; w++) begin
                            r = '{device: dev_id, n_words: n_words, has_word: 1'b1,
                                  index: w[4:0], word: payload_word(w), ret_en: ret_flag,
                                  last: (w + 1 == n_words)};
                            pending_words.push_back(r);
                        end
                    end
                end
                phase = HUNT;          // wrong tail byte is not taken as a header either
            end
            default: phase = HUNT;
        endcase
    endfunction

    // mostly back-to-back, now and then a short gap, rarely a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the result checker
    // ------------------------------------------------------------------
    // ready is high for one cycle, then low for a random stall (often none)
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= gap_len();
        end
    end

    always @(posedge aclk) begin : result_check
        frame_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result beat, tdata %h", $time, m_tdata);
            end else begin
                want = pending_words.pop_front();
                compare_field("source_id",     32'(want.device),   32'(m_tdata[7:0]));
                compare_field("word_count",    32'(want.n_words),  32'(m_tdata[12:8]));
                compare_field("word_index",    32'(want.index),    32'(m_tdata[17:13]));
                compare_field("data_word",     want.word,          m_tdata[49:18]);
                compare_field("return_enable", 32'(want.ret_en),   32'(m_tdata[50]));
                compare_field("tdata padding", 32'd0,              32'(m_tdata[55:51]));
                compare_field("has_word",      32'(want.has_word), 32'(m_tuser));
                compare_field("last",          32'(want.last),     32'(m_tlast));
            end
        end
    end

    // any beat on any channel counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("word_packet_deframer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // valid stays high across back-to-back beats; it only drops for a gap
    task automatic send_byte(input logic [7:0] b);
        int unsigned pause;
        pause = gap_len();
        if (pause != 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (!(phase == HUNT && b != hdr_value))
            beats_sent++;
        parse_byte(b);
    endtask

    task automatic write_reg(input logic [wpd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            wpd_pkg::REG_HEADER: hdr_value  = val;
            wpd_pkg::REG_TAIL:   tail_value = val;
            default:    ;
        endcase
    endtask

    // bring the parser back to hunting, collect every owed result, then let it go quiet
    task automatic settle_idle();
        while (phase != HUNT)
            send_byte(8'hFF);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // payload bytes lean towards all-zeros and all-ones
    function automatic logic [7:0] data_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // short frames dominate; the full 30 words turns up now and then
    function automatic logic [7:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 8'd0;
        else if (r < 82)
            return 8'($urandom_range(1, 4));
        else if (r < 96)
            return 8'($urandom_range(5, 12));
        else if (r < 98)
            return 8'($urandom_range(13, MAX_WORDS - 1));
        else
            return 8'(MAX_WORDS);
    endfunction

    task automatic send_frame(input logic [7:0] count, input bit good_tail);
        send_byte(hdr_value);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(count);
        if (count <= MAX_WORDS) begin
            repeat (count * WORD_BYTES) send_byte(data_byte());
            if (good_tail)
                send_byte(tail_value);
            else
                send_byte(tail_value ^ 8'($urandom_range(1, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty frame, one-word frames clearing then setting the return flag, an oversize
    // count equal to the header value, and a wrong tail equal to the header value.
    task automatic test_special_cases();
        logic [7:0] seq [$];
        gaps_on = 1'b1;
        write_reg(wpd_pkg::REG_HEADER, 8'hA5);
        write_reg(wpd_pkg::REG_TAIL, 8'h5A);
        write_reg(REG_SPARE_A, 8'h00);    // unmapped: header and tail must survive these
        write_reg(REG_SPARE_B, 8'hFF);
        seq = {8'hA5, 8'hFF, 8'h00, 8'h5A,
               8'hA5, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A,
               8'hA5, 8'h80, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A,
               8'hA5, 8'h22, 8'hA5,
               8'hA5, 8'h44, 8'h00, 8'hA5};
        foreach (seq[i])
            send_byte(seq[i]);
        settle_idle();
    endtask

    // Mostly well-formed frames with random content; the rest wrong tails, oversize
    // counts, truncated frames and line noise.
    task automatic test_frame_stream(input logic [7:0] hdr, input logic [7:0] tl,
                                     input int unsigned budget, input bit idling,
                                     input bit full_frame);
        int unsigned stop_at;
        int unsigned r;
        write_reg(wpd_pkg::REG_HEADER, hdr);
        write_reg(wpd_pkg::REG_TAIL, tl);
        stop_at = beats_sent + budget;
        if (full_frame) begin
            gaps_on = idling;
            send_frame(8'(MAX_WORDS), 1'b1);
        end
        while (beats_sent < stop_at) begin
            gaps_on = idling && ($urandom_range(0, 9) != 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(pick_count(), 1'b1);
            end else if (r < 80) begin
                send_frame(pick_count(), 1'b0);
            end else if (r < 87) begin
                send_frame(8'($urandom_range(MAX_WORDS + 1, 255)), 1'b1);
            end else if (r < 93) begin
                // cut short: whatever follows is swallowed as payload
                send_byte(hdr_value);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(1, 4)));
                repeat ($urandom_range(0, 3)) send_byte(data_byte());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(hdr_value);
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        settle_idle();
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= wpd_pkg::REG_HEADER;
        cfg_data   <= '0;
        gaps_on     = 1'b0;
        beats_sent  = 0;
        mismatch_count = 0;
        // mirror of the reset state
        hdr_value  = 8'h00;
        tail_value = 8'h00;
        phase      = HUNT;
        data_seen  = 0;
        data_due   = 0;
        dev_id     = 8'h00;
        n_words    = '0;
        ret_flag   = 1'b1;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_cases();
        // extremes first: no idling at all, then header and tail swapped
        test_frame_stream(8'h00, 8'hFF, 150, 1'b0, 1'b1);
        test_frame_stream(8'hFF, 8'h00, 70, 1'b1, 1'b0);
        // header and tail share a value, as they do out of reset
        test_frame_stream(8'h00, 8'h00, 60, 1'b1, 1'b0);
        test_frame_stream(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 150,
                          1'b1, 1'b1);

        if (mismatch_count == 0)
            $display("word_packet_deframer verification clean");
        else
            $display("word_packet_deframer verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wpd_pkg.sv
sv/wpd_ctrl.sv
sv/wpd_datapath.sv
sv/word_packet_deframer.sv
verif/word_packet_deframer_test.sv
